@@ rtl/core/rbmc_pkg.sv @@
// Shared widths, register indexes and payload types of the mip chain block.
`default_nettype none

package rbmc_pkg;

   // Field widths fixed by the interface
   localparam int CHAN_W     = 8;
   localparam int PAIR_W     = 9;
   localparam int SUM_W      = 10;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int LEVEL_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT = 1'd1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // Horizontal pair sums, one per channel
   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      pixel_type          color;
      logic               last_of_run;
      logic               chain_done;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/rbmc_req_if.sv @@
// Request channel of the mip chain block: one base pixel per handshake.
`default_nettype none

interface rbmc_req_if;
   logic                       valid;
   logic                       ready;
   logic [rbmc_pkg::CHAN_W-1:0] red;
   logic [rbmc_pkg::CHAN_W-1:0] green;
   logic [rbmc_pkg::CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rbmc_rsp_if.sv @@
// Response channel of the mip chain block: one mip pixel per handshake.
`default_nettype none

interface rbmc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rbmc_pkg::LEVEL_W-1:0] level;
   logic [rbmc_pkg::COORD_W-1:0] pixel_x;
   logic [rbmc_pkg::COORD_W-1:0] pixel_y;
   logic [rbmc_pkg::CHAN_W-1:0]  out_red;
   logic [rbmc_pkg::CHAN_W-1:0]  out_green;
   logic [rbmc_pkg::CHAN_W-1:0]  out_blue;
   logic                         last_of_run;
   logic                         chain_done;

   modport source (output valid, output level, output pixel_x, output pixel_y,
                   output out_red, output out_green, output out_blue,
                   output last_of_run, output chain_done, input ready);
   modport sink   (input valid, input level, input pixel_x, input pixel_y,
                   input out_red, input out_green, input out_blue,
                   input last_of_run, input chain_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgba8_box_mip_chain.sv @@
// Streaming mip chain generator: a row of level cells behind one output register.
//
// Usage: base pixels enter in raster order on the request channel (req_bus),
// one per handshake. Each request yields its level 0 echo and, whenever it
// completes a 2x2 block, the averaged pixel of the next level, and so on, in
// ascending level order on the response channel (rsp_bus). last_of_run marks
// the final response of a request; chain_done the final pixel of the smallest
// level. Base dimensions are set through csr_we/csr_index/csr_wdata while idle;
// a write restarts the frame at pixel zero of every level.
// Timing: at each level a request passes first through the level cell, which
// issues its response and line-store access, then through the registered
// line-store read and rounding on the way to the next cell. A new request is
// taken in the cycle after the last response of the previous run has entered
// the output register.
// Reset: dimensions return to 1x1 and all positions to zero; the line stores
// need no clearing, as every read follows a write in the same frame.
// Stall: while rsp_bus.ready is low the output register holds and the active
// cell waits; nothing is dropped.
`default_nettype none

module rgba8_box_mip_chain #(
   parameter int MAX_DIM    = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   rbmc_req_if.sink                          req_bus,
   rbmc_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [rbmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW = rbmc_pkg::DIM_W;

   logic [DW-1:0]        base_width_ff, base_width_in;
   logic [DW-1:0]        base_height_ff, base_height_in;
   logic [DW-1:0]        csr_dim;
   logic                 restart;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rbmc_pkg::result_type rsp_ff, rsp_in;
   logic                 req_accept, advance, fire_any;
   rbmc_pkg::result_type res_any;

   logic [MAX_LEVELS-1:0] link_valid;
   rbmc_pkg::pixel_type   link_pix [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] cell_valid;
   rbmc_pkg::result_type  cell_res [MAX_LEVELS];

   // Register writes, with out-of-range dimensions clamped
   always_comb begin
      csr_dim = DW'(csr_wdata);
      if (csr_wdata == '0) begin
         csr_dim = DW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_DIM)) begin
         csr_dim = DW'(MAX_DIM);
      end
      base_width_in  = base_width_ff;
      base_height_in = base_height_ff;
      restart        = 1'b0;
      if (csr_we) begin
         case (csr_index)
            rbmc_pkg::CSR_BASE_WIDTH: begin
               base_width_in = csr_dim;
               restart       = 1'b1;
            end
            rbmc_pkg::CSR_BASE_HEIGHT: begin
               base_height_in = csr_dim;
               restart        = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // Request side: one request in the chain at a time
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !busy_ff;
   assign advance      = !rsp_valid_ff || rsp_bus.ready;

   assign link_valid[0]     = req_accept;
   assign link_pix[0].red   = req_bus.red;
   assign link_pix[0].green = req_bus.green;
   assign link_pix[0].blue  = req_bus.blue;

   // Level cells
   for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
      if (k + 1 < MAX_LEVELS) begin : g_mid
         rbmc_cell #(
            .LEVEL      (k),
            .MAX_DIM    (MAX_DIM),
            .MAX_LEVELS (MAX_LEVELS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .restart     (restart),
            .base_width  (base_width_ff),
            .base_height (base_height_ff),
            .advance     (advance),
            .in_valid    (link_valid[k]),
            .in_pix      (link_pix[k]),
            .out_valid   (link_valid[k+1]),
            .out_pix     (link_pix[k+1]),
            .res_valid   (cell_valid[k]),
            .res         (cell_res[k])
         );
      end else begin : g_end
         rbmc_cell #(
            .LEVEL      (k),
            .MAX_DIM    (MAX_DIM),
            .MAX_LEVELS (MAX_LEVELS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .restart     (restart),
            .base_width  (base_width_ff),
            .base_height (base_height_ff),
            .advance     (advance),
            .in_valid    (link_valid[k]),
            .in_pix      (link_pix[k]),
            .out_valid   (),
            .out_pix     (),
            .res_valid   (cell_valid[k]),
            .res         (cell_res[k])
         );
      end
   end

   // Only the active cell drives a non-zero result
   always_comb begin
      res_any = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         res_any = res_any | cell_res[k];
      end
   end

   assign fire_any = (|cell_valid) && advance;

   always_comb begin
      rsp_valid_in = fire_any || (rsp_valid_ff && !rsp_bus.ready);
      rsp_in       = fire_any ? res_any : rsp_ff;
      busy_in      = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (fire_any && res_any.last_of_run) begin
         busy_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff  <= DW'(1);
         base_height_ff <= DW'(1);
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         base_width_ff  <= base_width_in;
         base_height_ff <= base_height_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.level       = rsp_ff.level;
   assign rsp_bus.pixel_x     = rsp_ff.pixel_x;
   assign rsp_bus.pixel_y     = rsp_ff.pixel_y;
   assign rsp_bus.out_red     = rsp_ff.color.red;
   assign rsp_bus.out_green   = rsp_ff.color.green;
   assign rsp_bus.out_blue    = rsp_ff.color.blue;
   assign rsp_bus.last_of_run = rsp_ff.last_of_run;
   assign rsp_bus.chain_done  = rsp_ff.chain_done;

endmodule

`default_nettype wire

@@ rtl/core/rbmc_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module rbmc_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/rbmc_cell.sv @@
// One mip level: position counters, left pixel, line store and 2x2 averaging.
`default_nettype none

module rbmc_cell #(
   parameter int LEVEL      = 0,
   parameter int MAX_DIM    = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic [rbmc_pkg::DIM_W-1:0]   base_width,
   input  logic [rbmc_pkg::DIM_W-1:0]   base_height,
   input  logic                         advance,
   input  logic                         in_valid,
   input  rbmc_pkg::pixel_type          in_pix,
   output logic                         out_valid,
   output rbmc_pkg::pixel_type          out_pix,
   output logic                         res_valid,
   output rbmc_pkg::result_type         res
);

   localparam int DW        = rbmc_pkg::DIM_W;
   localparam int CW        = rbmc_pkg::COORD_W;
   localparam int LW        = rbmc_pkg::LEVEL_W;
   localparam int PW        = rbmc_pkg::PAIR_W;
   localparam int SW        = rbmc_pkg::SUM_W;
   localparam int CH        = rbmc_pkg::CHAN_W;
   localparam int RAW_DEPTH = MAX_DIM >> (LEVEL + 1);
   localparam int DEPTH     = (RAW_DEPTH > 2) ? RAW_DEPTH : 2;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam bit END_CELL  = (LEVEL + 1 >= MAX_LEVELS);
   localparam logic [DW-1:0] ONE = DW'(1);
   localparam logic [LW-1:0] LEVEL_CODE = LW'(LEVEL);

   // Level dimension: halved with floor, never below one
   function automatic logic [DW-1:0] shrink(input logic [DW-1:0] base,
                                            input int unsigned steps);
      logic [DW-1:0] v;
      v = base >> steps;
      return (v == '0) ? ONE : v;
   endfunction

   // Rounded average of four samples held as a sum
   function automatic logic [CH-1:0] avg4(input logic [SW-1:0] sum);
      logic [SW-1:0] t;
      t = sum + SW'(2);
      return t[SW-1:2];
   endfunction

   function automatic logic [SW-1:0] vsum(input logic [PW-1:0] pair,
                                          input logic [PW-1:0] line,
                                          input logic         dbl);
      return dbl ? {pair, 1'b0} : ({1'b0, pair} + {1'b0, line});
   endfunction

   function automatic logic [PW-1:0] hsum(input logic [CH-1:0] left,
                                          input logic [CH-1:0] right,
                                          input logic          dbl);
      return dbl ? {right, 1'b0} : ({1'b0, left} + {1'b0, right});
   endfunction

   logic                a_valid_ff, a_valid_in;
   rbmc_pkg::pixel_type a_pix_ff, a_pix_in;
   logic [DW-1:0]       col_ff, col_in;
   logic [DW-1:0]       row_ff, row_in;
   rbmc_pkg::pixel_type left_ff, left_in;
   logic                b_valid_ff, b_valid_in;
   rbmc_pkg::pair_type  b_pair_ff, b_pair_in;
   logic                b_double_ff, b_double_in;

   logic [DW-1:0]       src_w, src_h, dst_w, dst_h;
   logic                src_w_one, src_h_one, is_last;
   logic [DW:0]         col_next, row_next;
   logic                col_wrap, row_wrap, col_in_pair, row_in_pair;
   logic                have_pair, store_left, line_use, line_wr, line_rd, have_out;
   logic                fire;
   rbmc_pkg::pair_type  pair_sum, line_data;
   logic [ADDR_W-1:0]   line_addr;

   // Geometry of this level and the next
   assign src_w     = shrink(base_width,  LEVEL);
   assign src_h     = shrink(base_height, LEVEL);
   assign dst_w     = shrink(base_width,  LEVEL + 1);
   assign dst_h     = shrink(base_height, LEVEL + 1);
   assign src_w_one = (src_w == ONE);
   assign src_h_one = (src_h == ONE);
   assign is_last   = END_CELL || (src_w_one && src_h_one);

   // Position in the level
   assign col_next    = {1'b0, col_ff} + (DW + 1)'(1);
   assign row_next    = {1'b0, row_ff} + (DW + 1)'(1);
   assign col_wrap    = (col_next >= {1'b0, src_w});
   assign row_wrap    = (row_next >= {1'b0, src_h});
   assign col_in_pair = ({1'b0, col_ff} < {dst_w, 1'b0});
   assign row_in_pair = ({1'b0, row_ff} < {dst_h, 1'b0});

   // Which part of a 2x2 block this pixel is
   assign have_pair  = !is_last && (src_w_one || (col_in_pair && col_ff[0]));
   assign store_left = !is_last && !src_w_one && col_in_pair && !col_ff[0];
   assign line_use   = have_pair && !src_h_one && row_in_pair;
   assign line_wr    = line_use && !row_ff[0];
   assign line_rd    = line_use && row_ff[0];
   assign have_out   = have_pair && (src_h_one || line_rd);

   assign fire = a_valid_ff && advance;

   assign pair_sum.red   = hsum(left_ff.red,   a_pix_ff.red,   src_w_one);
   assign pair_sum.green = hsum(left_ff.green, a_pix_ff.green, src_w_one);
   assign pair_sum.blue  = hsum(left_ff.blue,  a_pix_ff.blue,  src_w_one);
   assign line_addr      = src_w_one ? '0 : ADDR_W'(col_ff >> 1);

   // Line store of upper-row pair sums
   rbmc_ram #(
      .WIDTH ($bits(rbmc_pkg::pair_type)),
      .DEPTH (DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (fire && line_wr),
      .wr_addr (line_addr),
      .wr_data (pair_sum),
      .rd_en   (fire && line_rd),
      .rd_addr (line_addr),
      .rd_data (line_data)
   );

   // Next-state logic
   always_comb begin
      a_valid_in  = in_valid || (a_valid_ff && !fire);
      a_pix_in    = in_valid ? in_pix : a_pix_ff;
      left_in     = (fire && store_left) ? a_pix_ff : left_ff;
      b_valid_in  = fire && have_out;
      b_pair_in   = pair_sum;
      b_double_in = src_h_one;
      col_in      = col_ff;
      row_in      = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (fire) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[DW-1:0];
         end else begin
            col_in = col_next[DW-1:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_pix_ff    <= a_pix_in;
      left_ff     <= left_in;
      b_pair_ff   <= b_pair_in;
      b_double_ff <= b_double_in;
   end

   // Vertical sum and rounding, handed to the next level
   assign out_valid     = b_valid_ff;
   assign out_pix.red   = avg4(vsum(b_pair_ff.red,   line_data.red,   b_double_ff));
   assign out_pix.green = avg4(vsum(b_pair_ff.green, line_data.green, b_double_ff));
   assign out_pix.blue  = avg4(vsum(b_pair_ff.blue,  line_data.blue,  b_double_ff));

   // Result of this level, zero when idle so the top can OR them
   assign res_valid = a_valid_ff;
   always_comb begin
      res = '0;
      if (a_valid_ff) begin
         res.level       = LEVEL_CODE;
         res.pixel_x     = col_ff[CW-1:0];
         res.pixel_y     = row_ff[CW-1:0];
         res.color       = a_pix_ff;
         res.last_of_run = !have_out;
         res.chain_done  = is_last && (col_next == {1'b0, src_w}) &&
                           (row_next == {1'b0, src_h});
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rbmc_checker.sv @@
// Port-level checks of the mip chain block and their binding to the top level.
`default_nettype none

module rbmc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rbmc_pkg::LEVEL_W-1:0] rsp_level,
   input logic [rbmc_pkg::COORD_W-1:0] rsp_pixel_x,
   input logic [rbmc_pkg::COORD_W-1:0] rsp_pixel_y,
   input logic [rbmc_pkg::CHAN_W-1:0]  rsp_red,
   input logic [rbmc_pkg::CHAN_W-1:0]  rsp_green,
   input logic [rbmc_pkg::CHAN_W-1:0]  rsp_blue,
   input logic                         rsp_last_of_run,
   input logic                         rsp_chain_done
);

   // A stalled response keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_level, rsp_pixel_x, rsp_pixel_y, rsp_red, rsp_green,
                  rsp_blue, rsp_last_of_run, rsp_chain_done}))
      else $error("stalled response changed");

   // The final pixel of the chain always closes its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chain_done |-> rsp_last_of_run)
      else $error("chain_done without last_of_run");

   // A taken request blocks the next one until its run is issued
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a run is in flight");

   // No response is offered and requests are accepted straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind rgba8_box_mip_chain rbmc_checker u_rbmc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_level       (rsp_bus.level),
   .rsp_pixel_x     (rsp_bus.pixel_x),
   .rsp_pixel_y     (rsp_bus.pixel_y),
   .rsp_red         (rsp_bus.out_red),
   .rsp_green       (rsp_bus.out_green),
   .rsp_blue        (rsp_bus.out_blue),
   .rsp_last_of_run (rsp_bus.last_of_run),
   .rsp_chain_done  (rsp_bus.chain_done)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench of the streaming RGB mip chain generator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM    = 4096;
   localparam int MAX_LEVELS = 13;

   localparam int CSR_IDX_W  = rbmc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = rbmc_pkg::CSR_DATA_W;
   localparam int LEVEL_W    = rbmc_pkg::LEVEL_W;
   localparam int COORD_W    = rbmc_pkg::COORD_W;
   localparam int PAIR_W     = rbmc_pkg::PAIR_W;
   localparam int CHAN_W     = rbmc_pkg::CHAN_W;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rbmc_req_if req_bus ();
   rbmc_rsp_if rsp_bus ();

   rgba8_box_mip_chain #(
      .MAX_DIM    (MAX_DIM),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the block: dimensions, level geometry, positions and stores
   int unsigned          base_w;
   int unsigned          base_h;
   int unsigned          lvl_w [MAX_LEVELS];
   int unsigned          lvl_h [MAX_LEVELS];
   int unsigned          lvl_base [MAX_LEVELS];
   int unsigned          lvl_total;
   int unsigned          col_pos [MAX_LEVELS];
   int unsigned          row_pos [MAX_LEVELS];
   rbmc_pkg::pixel_type  left_px [MAX_LEVELS];
   rbmc_pkg::pair_type   line_sums [MAX_DIM];

   rbmc_pkg::result_type mip_pixels_due [$];
   int unsigned          mismatch_count;
   int unsigned          send_idle_pct;
   int unsigned          recv_stall_pct;

   // Level sizes halve with floor, never below one; positions restart
   function automatic void rebuild_levels();
      int unsigned w, h, n, acc;
      w = base_w;
      h = base_h;
      n = 1;
      acc = 0;
      lvl_w[0] = w;
      lvl_h[0] = h;
      lvl_base[0] = 0;
      while (n < MAX_LEVELS && (w > 1 || h > 1)) begin
         w = (w / 2 > 1) ? w / 2 : 1;
         h = (h / 2 > 1) ? h / 2 : 1;
         lvl_w[n] = w;
         lvl_h[n] = h;
         acc += w;
         if (n + 1 < MAX_LEVELS) lvl_base[n] = acc;
         n++;
      end
      lvl_total = n;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
      end
   endfunction

   // Zero acts as one, anything past the maximum as the maximum
   function automatic void apply_dim_reg(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] value);
      int unsigned dim;
      dim = value;
      if (dim == 0) dim = 1;
      if (dim > MAX_DIM) dim = MAX_DIM;
      if (idx == rbmc_pkg::CSR_BASE_WIDTH) base_w = dim;
      else base_h = dim;
      rebuild_levels();
   endfunction

   // Walk one base pixel down the chain and queue every pixel it completes
   function automatic void compute_mip_run(input rbmc_pkg::pixel_type px);
      rbmc_pkg::result_type run [MAX_LEVELS];
      rbmc_pkg::pixel_type  cur;
      rbmc_pkg::pair_type   ent;
      int unsigned lv, n, x, y, sw, sh, dw, dh, dx, idx, sr, sg, sb;
      bit          have_pair, have_out;
      cur = px;
      n = 0;
      for (lv = 0; lv < MAX_LEVELS; lv++) begin
         x = col_pos[lv];
         y = row_pos[lv];
         sw = lvl_w[lv];
         sh = lvl_h[lv];
         have_pair = 1'b0;
         have_out = 1'b0;
         sr = 0;
         sg = 0;
         sb = 0;
         dx = 0;
         run[n].level = LEVEL_W'(lv);
         run[n].pixel_x = COORD_W'(x);
         run[n].pixel_y = COORD_W'(y);
         run[n].color = cur;
         run[n].last_of_run = 1'b0;
         run[n].chain_done = (lv + 1 == lvl_total && x + 1 == sw && y + 1 == sh);
         n++;
         if (x + 1 >= sw) begin
            col_pos[lv] = 0;
            row_pos[lv] = (y + 1 >= sh) ? 0 : y + 1;
         end else begin
            col_pos[lv] = x + 1;
         end
         if (lv + 1 >= lvl_total) break;
         dw = lvl_w[lv + 1];
         dh = lvl_h[lv + 1];
         // horizontal pair: a single column pairs with itself
         if (sw == 1) begin
            sr = 2 * cur.red;
            sg = 2 * cur.green;
            sb = 2 * cur.blue;
            have_pair = 1'b1;
         end else if (x < 2 * dw) begin
            if ((x & 1) == 0) begin
               left_px[lv] = cur;
            end else begin
               sr = left_px[lv].red + cur.red;
               sg = left_px[lv].green + cur.green;
               sb = left_px[lv].blue + cur.blue;
               have_pair = 1'b1;
               dx = x >> 1;
            end
         end
         // vertical pair: a single row pairs with itself, else via line store
         if (have_pair) begin
            if (sh == 1) begin
               sr *= 2;
               sg *= 2;
               sb *= 2;
               have_out = 1'b1;
            end else if (y < 2 * dh) begin
               idx = lvl_base[lv] + dx;
               if (idx < MAX_DIM) begin
                  if ((y & 1) == 0) begin
                     line_sums[idx] = '{red: PAIR_W'(sr), green: PAIR_W'(sg),
                                        blue: PAIR_W'(sb)};
                  end else begin
                     ent = line_sums[idx];
                     sr += ent.red;
                     sg += ent.green;
                     sb += ent.blue;
                     have_out = 1'b1;
                  end
               end
            end
         end
         if (!have_out) break;
         cur.red = CHAN_W'((sr + 2) >> 2);
         cur.green = CHAN_W'((sg + 2) >> 2);
         cur.blue = CHAN_W'((sb + 2) >> 2);
      end
      run[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) mip_pixels_due = {mip_pixels_due, run[i]};
   endfunction

   // One line per mismatch; printing stops after a hundred, counting does not
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) $display("%0t ns: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response stalls, redrawn every cycle
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      rbmc_pkg::result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            compute_mip_run('{red: req_bus.red, green: req_bus.green, blue: req_bus.blue});
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (mip_pixels_due.size() == 0) begin
               report_mismatch($sformatf("response L%0d (%0d,%0d) with nothing expected",
                                         rsp_bus.level, rsp_bus.pixel_x, rsp_bus.pixel_y));
            end else begin
               want = mip_pixels_due.pop_front();
               if (rsp_bus.level !== want.level)
                  report_mismatch($sformatf("level %0d, expected %0d",
                                            rsp_bus.level, want.level));
               if (rsp_bus.pixel_x !== want.pixel_x)
                  report_mismatch($sformatf("L%0d pixel_x %0d, expected %0d",
                                            want.level, rsp_bus.pixel_x, want.pixel_x));
               if (rsp_bus.pixel_y !== want.pixel_y)
                  report_mismatch($sformatf("L%0d pixel_y %0d, expected %0d",
                                            want.level, rsp_bus.pixel_y, want.pixel_y));
               if (rsp_bus.out_red !== want.color.red)
                  report_mismatch($sformatf("L%0d (%0d,%0d) red %0d, expected %0d",
                                            want.level, want.pixel_x, want.pixel_y,
                                            rsp_bus.out_red, want.color.red));
               if (rsp_bus.out_green !== want.color.green)
                  report_mismatch($sformatf("L%0d (%0d,%0d) green %0d, expected %0d",
                                            want.level, want.pixel_x, want.pixel_y,
                                            rsp_bus.out_green, want.color.green));
               if (rsp_bus.out_blue !== want.color.blue)
                  report_mismatch($sformatf("L%0d (%0d,%0d) blue %0d, expected %0d",
                                            want.level, want.pixel_x, want.pixel_y,
                                            rsp_bus.out_blue, want.color.blue));
               if (rsp_bus.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("L%0d (%0d,%0d) last_of_run %0b, expected %0b",
                                            want.level, want.pixel_x, want.pixel_y,
                                            rsp_bus.last_of_run, want.last_of_run));
               if (rsp_bus.chain_done !== want.chain_done)
                  report_mismatch($sformatf("L%0d (%0d,%0d) chain_done %0b, expected %0b",
                                            want.level, want.pixel_x, want.pixel_y,
                                            rsp_bus.chain_done, want.chain_done));
            end
         end
      end
   end

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   // Send one request; valid stays high afterwards unless a gap is drawn
   task automatic send_pixel(input rbmc_pkg::pixel_type px);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.red = px.red;
      req_bus.green = px.green;
      req_bus.blue = px.blue;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(rbmc_pkg::pixel_type'(24'($urandom())));
   endtask

   // Hold off requests until every expected pixel has come out
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (mip_pixels_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      apply_dim_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure_dims(input int unsigned w, input int unsigned h);
      wait_drained();
      write_reg(rbmc_pkg::CSR_BASE_WIDTH, CSR_DATA_W'(w));
      write_reg(rbmc_pkg::CSR_BASE_HEIGHT, CSR_DATA_W'(h));
   endtask

   // 1x1 after reset: every request is its own whole chain
   task automatic test_reset_size();
      send_pixel(rbmc_pkg::pixel_type'{8'd0, 8'd0, 8'd0});
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd255, 8'd255});
   endtask

   // Zero dimensions behave as 1x1
   task automatic test_zero_dims();
      configure_dims(0, 0);
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd0, 8'd170});
   endtask

   // Saturation and rounding half up on one 2x2 block
   task automatic test_box_rounding();
      configure_dims(2, 2);
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd1, 8'd0});
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd1, 8'd0});
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd0, 8'd0});
      send_pixel(rbmc_pkg::pixel_type'{8'd255, 8'd0, 8'd1});
   endtask

   // Odd source: trailing column and row dropped
   task automatic test_odd_drop();
      configure_dims(3, 3);
      send_frame(9);
   endtask

   // Single column or row reused as its own pair
   task automatic test_thin_frames();
      configure_dims(1, 4);
      send_frame(4);
      configure_dims(4, 1);
      send_frame(4);
   endtask

   // Sender pauses mid-frame until the block has drained
   task automatic test_midframe_pause();
      set_idling(0, 60);
      configure_dims(4, 4);
      send_frame(6);
      wait_drained();
      send_frame(10);
      set_idling(0, 0);
   endtask

   // Largest sizes: over-range width clamps, wide and tall partial frames
   task automatic test_extreme_dims();
      set_idling(22, 22);
      configure_dims(8191, 1);
      send_frame(128);
      configure_dims(2, MAX_DIM);
      send_frame(12);
      set_idling(0, 0);
   endtask

   // Random frames, mostly whole, some cut short, across idling phases
   task automatic test_random_frames();
      int unsigned sent, frame, count;
      sent = 0;
      frame = 0;
      while (sent < 320) begin
         case (frame % 5)
            1: set_idling(60, 0);
            2: set_idling(0, 60);
            3: set_idling(22, 22);
            default: set_idling(0, 0);
         endcase
         if (frame == 0 || $urandom_range(9) < 7) begin
            if ($urandom_range(9) == 0)
               configure_dims($urandom_range(0, 40), $urandom_range(0, 4));
            else
               configure_dims($urandom_range(1, 8), $urandom_range(1, 8));
         end
         count = base_w * base_h;
         if ($urandom_range(99) < 15) count = $urandom_range(1, count);
         send_frame(count);
         sent += count;
         frame++;
      end
   endtask

   // Main sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = rbmc_pkg::CSR_BASE_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      mismatch_count = 0;
      set_idling(0, 0);
      base_w = 1;
      base_h = 1;
      rebuild_levels();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_reset_size();
      test_zero_dims();
      test_box_rounding();
      test_odd_drop();
      test_thin_frames();
      test_midframe_pause();
      test_extreme_dims();
      test_random_frames();

      wait_drained();
      repeat (30) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("rgba8_box_mip_chain verification clean");
      end else begin
         $display("rgba8_box_mip_chain verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #30_000_000;
      $display("rgba8_box_mip_chain verification failed");
      $finish;
   end

endmodule
